@@ sv/cisc_pkg.sv @@
package cisc_pkg;

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_READ  = 2'd1,
        CMD_ACK   = 2'd2
    } t_cmd;

    typedef enum logic [2:0] {
        PH_FETCH = 3'd0,
        PH_IMM1  = 3'd1,
        PH_IMM2  = 3'd2,
        PH_DATA  = 3'd3,
        PH_CB    = 3'd4,
        PH_WR1   = 3'd5,
        PH_WR2   = 3'd6
    } t_phase;

    localparam logic [1:0] KIND_READ  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_FAULT = 2'd2;

    localparam logic [7:0] OP_NOP      = 8'h00;
    localparam logic [7:0] OP_INC_C    = 8'h0c;
    localparam logic [7:0] OP_LD_C_D8  = 8'h0e;
    localparam logic [7:0] OP_RRCA     = 8'h0f;
    localparam logic [7:0] OP_LD_DE    = 8'h11;
    localparam logic [7:0] OP_LD_A_DE  = 8'h1a;
    localparam logic [7:0] OP_JR_NZ    = 8'h20;
    localparam logic [7:0] OP_LD_HL    = 8'h21;
    localparam logic [7:0] OP_LD_SP    = 8'h31;
    localparam logic [7:0] OP_LD_HLD_A = 8'h32;
    localparam logic [7:0] OP_LD_A_D8  = 8'h3e;
    localparam logic [7:0] OP_LD_HL_A  = 8'h77;
    localparam logic [7:0] OP_XOR_A    = 8'haf;
    localparam logic [7:0] OP_PREFIX   = 8'hcb;
    localparam logic [7:0] OP_CALL     = 8'hcd;
    localparam logic [7:0] OP_LDH_A8_A = 8'he0;
    localparam logic [7:0] OP_LD_C_A   = 8'he2;

    localparam logic [7:0] CB_SLA_B    = 8'h20;
    localparam logic [7:0] CB_BIT7_H   = 8'h7c;

    localparam logic [7:0] HIGH_PAGE   = 8'hFF;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] read_data;
    } t_in;

    typedef struct packed {
        logic [1:0]  access_kind;
        logic [15:0] bus_address;
        logic [7:0]  write_byte;
        logic [15:0] out_af;
        logic [15:0] out_bc;
        logic [15:0] out_de;
        logic [15:0] out_hl;
        logic [15:0] out_sp;
        logic [15:0] out_pc;
    } t_out;

    // Flags are Z N H C from bit 3 down to bit 0.
    typedef struct packed {
        logic [7:0]  a;
        logic [3:0]  f;
        logic [15:0] bc;
        logic [15:0] de;
        logic [15:0] hl;
        logic [15:0] sp;
        logic [15:0] pc;
        t_phase      phase;
        logic [7:0]  opcode;
        logic [7:0]  op_lo;
        logic [7:0]  op_hi;
        logic        fault;
    } t_core;

endpackage

@@ sv/cisc_step.sv @@
module cisc_step
    import cisc_pkg::*;
(
    input  t_core i_cur,
    input  t_in   i_req,
    output t_core o_nxt
);

    logic [7:0] v_d;
    logic [7:0] v_b;
    logic [7:0] v_r;
    logic [7:0] v_c;

    always_comb begin
        v_d   = i_req.read_data;
        v_b   = i_cur.bc[15:8];
        v_r   = {v_b[6:0], 1'b0};
        v_c   = i_cur.bc[7:0] + 8'd1;
        o_nxt = i_cur;
        if (!i_cur.fault) begin
            case (i_req.command)
                CMD_START: begin
                    o_nxt.phase = PH_FETCH;
                end
                CMD_READ: begin
                    case (i_cur.phase)
                        PH_IMM1: begin
                            o_nxt.pc    = i_cur.pc + 16'd1;
                            o_nxt.op_lo = v_d;
                            o_nxt.phase = PH_FETCH;
                            case (i_cur.opcode)
                                OP_LD_C_D8: o_nxt.bc[7:0] = v_d;
                                OP_LD_A_D8: o_nxt.a = v_d;
                                OP_JR_NZ: begin
                                    if (!i_cur.f[3]) begin
                                        o_nxt.pc = i_cur.pc + 16'd1 + {{8{v_d[7]}}, v_d};
                                    end
                                end
                                OP_LDH_A8_A: o_nxt.phase = PH_WR1;
                                default: o_nxt.phase = PH_IMM2;
                            endcase
                        end
                        PH_IMM2: begin
                            o_nxt.pc    = i_cur.pc + 16'd1;
                            o_nxt.op_hi = v_d;
                            o_nxt.phase = PH_FETCH;
                            case (i_cur.opcode)
                                OP_LD_DE: o_nxt.de = {v_d, i_cur.op_lo};
                                OP_LD_HL: o_nxt.hl = {v_d, i_cur.op_lo};
                                OP_LD_SP: o_nxt.sp = {v_d, i_cur.op_lo};
                                default: begin
                                    o_nxt.sp    = i_cur.sp - 16'd1;
                                    o_nxt.phase = PH_WR1;
                                end
                            endcase
                        end
                        PH_DATA: begin
                            o_nxt.a     = v_d;
                            o_nxt.phase = PH_FETCH;
                        end
                        PH_CB: begin
                            o_nxt.pc    = i_cur.pc + 16'd1;
                            o_nxt.phase = PH_FETCH;
                            if (v_d == CB_SLA_B) begin
                                o_nxt.bc[15:8] = v_r;
                                o_nxt.f        = {v_r == 8'd0, 1'b0, 1'b0, v_b[7]};
                            end else if (v_d == CB_BIT7_H) begin
                                o_nxt.f = {~i_cur.hl[15], 1'b0, 1'b1, i_cur.f[0]};
                            end else begin
                                o_nxt.fault = 1'b1;
                            end
                        end
                        PH_WR1, PH_WR2: begin
                            o_nxt = i_cur;
                        end
                        default: begin
                            o_nxt.pc     = i_cur.pc + 16'd1;
                            o_nxt.opcode = v_d;
                            o_nxt.phase  = PH_FETCH;
                            case (v_d)
                                OP_NOP: o_nxt.phase = PH_FETCH;
                                OP_INC_C: begin
                                    o_nxt.bc[7:0] = v_c;
                                    o_nxt.f = {v_c == 8'd0, 1'b0,
                                               i_cur.bc[3:0] == 4'hF, i_cur.f[0]};
                                end
                                OP_LD_C_D8, OP_LD_A_D8, OP_JR_NZ, OP_LDH_A8_A,
                                OP_LD_DE, OP_LD_HL, OP_LD_SP, OP_CALL: begin
                                    o_nxt.phase = PH_IMM1;
                                end
                                OP_LD_A_DE: o_nxt.phase = PH_DATA;
                                OP_LD_HLD_A, OP_LD_HL_A, OP_LD_C_A: begin
                                    o_nxt.phase = PH_WR1;
                                end
                                OP_XOR_A: begin
                                    o_nxt.a = 8'd0;
                                    o_nxt.f = 4'b1000;
                                end
                                OP_RRCA: begin
                                    o_nxt.a = {i_cur.a[0], i_cur.a[7:1]};
                                    o_nxt.f = {3'b000, i_cur.a[0]};
                                end
                                OP_PREFIX: o_nxt.phase = PH_CB;
                                default: o_nxt.fault = 1'b1;
                            endcase
                        end
                    endcase
                end
                CMD_ACK: begin
                    if (i_cur.phase == PH_WR1) begin
                        o_nxt.phase = PH_FETCH;
                        if (i_cur.opcode == OP_LD_HLD_A) begin
                            o_nxt.hl = i_cur.hl - 16'd1;
                        end else if (i_cur.opcode == OP_CALL) begin
                            o_nxt.sp    = i_cur.sp - 16'd1;
                            o_nxt.phase = PH_WR2;
                        end
                    end else if (i_cur.phase == PH_WR2) begin
                        o_nxt.pc    = {i_cur.op_hi, i_cur.op_lo};
                        o_nxt.phase = PH_FETCH;
                    end
                end
                default: begin
                    o_nxt = i_cur;
                end
            endcase
        end
    end

endmodule

@@ sv/cpu_instruction_subset_core_unit.sv @@
// An 8-bit CPU core that runs a subset of its instruction set over a byte bus.
// The input channel carries one bus event per request: a start command, a byte
// returned for the last read, or a write acknowledge. The output channel
// carries one answer per request: the next bus access (read, write, or fault)
// and the register pairs after the event.
// Each request updates the core state in the cycle it is accepted, and its
// answer is valid in the output register on the following cycle; one request
// can be taken every cycle while the receiver takes each answer. The decode
// and execute logic lies combinationally between the state registers and the
// output register.
// Reset clears the core state and output valid, returns the core to opcode
// fetch, and clears the fault. An unknown opcode latches a fault until reset.
// When the receiver stalls, the answer waits in the output register and the
// input ready drops until that answer is taken; ready follows the receiver's
// ready in the same cycle, so a full register empties and refills at once.
module cpu_instruction_subset_core_unit
    import cisc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    t_core r_core;
    t_core n_core;
    logic  r_out_valid;
    t_out  r_out_data;
    t_out  n_out_data;
    logic  w_take;

    cisc_step u_step (
        .i_cur (r_core),
        .i_req (i_in_data),
        .o_nxt (n_core)
    );

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign w_take      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_comb begin
        n_out_data.access_kind = KIND_READ;
        n_out_data.bus_address = n_core.pc;
        n_out_data.write_byte  = 8'd0;
        n_out_data.out_af      = {n_core.a, n_core.f, 4'b0000};
        n_out_data.out_bc      = n_core.bc;
        n_out_data.out_de      = n_core.de;
        n_out_data.out_hl      = n_core.hl;
        n_out_data.out_sp      = n_core.sp;
        n_out_data.out_pc      = n_core.pc;
        if (n_core.fault) begin
            n_out_data.access_kind = KIND_FAULT;
        end else if (n_core.phase == PH_DATA) begin
            n_out_data.bus_address = n_core.de;
        end else if (n_core.phase == PH_WR1 || n_core.phase == PH_WR2) begin
            n_out_data.access_kind = KIND_WRITE;
            n_out_data.write_byte  = n_core.a;
            case (n_core.opcode)
                OP_LD_HLD_A, OP_LD_HL_A: n_out_data.bus_address = n_core.hl;
                OP_LDH_A8_A: n_out_data.bus_address = {HIGH_PAGE, n_core.op_lo};
                OP_LD_C_A:   n_out_data.bus_address = {HIGH_PAGE, n_core.bc[7:0]};
                default: begin
                    n_out_data.bus_address = n_core.sp;
                    n_out_data.write_byte  = (n_core.phase == PH_WR1) ?
                                             n_core.pc[15:8] : n_core.pc[7:0];
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_core      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_take) begin
                r_core      <= n_core;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out_data <= n_out_data;
        end
    end

endmodule

@@ tb/sv/cpu_instruction_subset_core_unit_tb.sv @@
`timescale 1ns / 1ps

module cpu_instruction_subset_core_unit_tb;
    import cisc_pkg::*;

    localparam logic [1:0] CMD_NONE = 2'd3;
    localparam int FLAG_Z = 3;
    localparam int FLAG_C = 0;
    localparam int NUM_OPS = 17;
    localparam int RANDOM_REQUESTS = 850;
    localparam int LONG_HOLD = 300;
    localparam int STALL_LIMIT = 2000;

    class core_scoreboard;
        t_phase      phase;
        logic [7:0]  acc;
        logic [3:0]  flags;
        logic [15:0] bc, de, hl, sp, pc;
        logic [7:0]  opcode, op_lo, op_hi;
        bit          fault;
        t_out        bus_answers_q[$];
        int unsigned mismatches, requests_seen, answers_checked, decodes, writes;

        function new();
            phase = PH_FETCH;
            acc = '0;
            flags = '0;
            bc = '0;
            de = '0;
            hl = '0;
            sp = '0;
            pc = '0;
            opcode = '0;
            op_lo = '0;
            op_hi = '0;
            fault = 1'b0;
            mismatches = 0;
            requests_seen = 0;
            answers_checked = 0;
            decodes = 0;
            writes = 0;
        endfunction

        function void decode_opcode(logic [7:0] op);
            logic [7:0] r;
            phase = PH_FETCH;
            decodes++;
            case (op)
                OP_NOP: ;
                OP_INC_C: begin
                    r = bc[7:0] + 8'd1;
                    flags = {r == 8'd0, 1'b0, bc[3:0] == 4'hF, flags[FLAG_C]};
                    bc[7:0] = r;
                end
                OP_LD_C_D8, OP_LD_A_D8, OP_JR_NZ, OP_LDH_A8_A,
                OP_LD_DE, OP_LD_HL, OP_LD_SP, OP_CALL: phase = PH_IMM1;
                OP_LD_A_DE: phase = PH_DATA;
                OP_LD_HLD_A, OP_LD_HL_A, OP_LD_C_A: phase = PH_WR1;
                OP_XOR_A: begin
                    acc = 8'd0;
                    flags = 4'b1000;
                end
                OP_RRCA: begin
                    flags = {3'b000, acc[0]};
                    acc = {acc[0], acc[7:1]};
                end
                OP_PREFIX: phase = PH_CB;
                default: fault = 1'b1;
            endcase
        endfunction

        function void execute_prefixed(logic [7:0] op);
            logic [7:0] r;
            phase = PH_FETCH;
            if (op == CB_SLA_B) begin
                r = {bc[14:8], 1'b0};
                flags = {r == 8'd0, 1'b0, 1'b0, bc[15]};
                bc[15:8] = r;
            end else if (op == CB_BIT7_H) begin
                flags = {~hl[15], 1'b0, 1'b1, flags[FLAG_C]};
            end else begin
                fault = 1'b1;
            end
        endfunction

        function void take_read_byte(logic [7:0] d);
            case (phase)
                PH_IMM1: begin
                    pc = pc + 16'd1;
                    op_lo = d;
                    phase = PH_FETCH;
                    case (opcode)
                        OP_LD_C_D8: bc[7:0] = d;
                        OP_LD_A_D8: acc = d;
                        OP_JR_NZ: begin
                            if (!flags[FLAG_Z]) pc = pc + {{8{d[7]}}, d};
                        end
                        OP_LDH_A8_A: phase = PH_WR1;
                        default: phase = PH_IMM2;
                    endcase
                end
                PH_IMM2: begin
                    pc = pc + 16'd1;
                    op_hi = d;
                    phase = PH_FETCH;
                    case (opcode)
                        OP_LD_DE: de = {d, op_lo};
                        OP_LD_HL: hl = {d, op_lo};
                        OP_LD_SP: sp = {d, op_lo};
                        default: begin
                            sp = sp - 16'd1;
                            phase = PH_WR1;
                        end
                    endcase
                end
                PH_DATA: begin
                    acc = d;
                    phase = PH_FETCH;
                end
                PH_CB: begin
                    pc = pc + 16'd1;
                    execute_prefixed(d);
                end
                PH_WR1, PH_WR2: ;
                default: begin
                    pc = pc + 16'd1;
                    opcode = d;
                    decode_opcode(d);
                end
            endcase
        endfunction

        function void take_write_ack();
            if (phase == PH_WR1) begin
                phase = PH_FETCH;
                if (opcode == OP_LD_HLD_A) begin
                    hl = hl - 16'd1;
                end else if (opcode == OP_CALL) begin
                    sp = sp - 16'd1;
                    phase = PH_WR2;
                end
            end else if (phase == PH_WR2) begin
                pc = {op_hi, op_lo};
                phase = PH_FETCH;
            end
        endfunction

        function t_out next_access();
            t_out o;
            o = '0;
            o.access_kind = KIND_READ;
            o.bus_address = pc;
            if (fault) begin
                o.access_kind = KIND_FAULT;
            end else if (phase == PH_DATA) begin
                o.bus_address = de;
            end else if (phase == PH_WR1 || phase == PH_WR2) begin
                o.access_kind = KIND_WRITE;
                o.write_byte = acc;
                case (opcode)
                    OP_LD_HLD_A, OP_LD_HL_A: o.bus_address = hl;
                    OP_LDH_A8_A: o.bus_address = {HIGH_PAGE, op_lo};
                    OP_LD_C_A: o.bus_address = {HIGH_PAGE, bc[7:0]};
                    default: begin
                        o.bus_address = sp;
                        o.write_byte = (phase == PH_WR1) ? pc[15:8] : pc[7:0];
                    end
                endcase
            end
            o.out_af = {acc, flags, 4'h0};
            o.out_bc = bc;
            o.out_de = de;
            o.out_hl = hl;
            o.out_sp = sp;
            o.out_pc = pc;
            return o;
        endfunction

        function void note_request(t_in req);
            t_out o;
            requests_seen++;
            if (!fault) begin
                case (req.command)
                    CMD_START: phase = PH_FETCH;
                    CMD_READ: take_read_byte(req.read_data);
                    CMD_ACK: take_write_ack();
                    default: ;
                endcase
            end
            o = next_access();
            if (o.access_kind == KIND_WRITE) writes++;
            bus_answers_q.push_back(o);
        endfunction

        function void check_field(string name, logic [15:0] want, logic [15:0] got);
            if (want !== got) begin
                $error("%s expected %h got %h", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_answer(t_out got);
            t_out want;
            if (bus_answers_q.size() == 0) begin
                $error("answer arrived with no request outstanding");
                mismatches++;
                return;
            end
            want = bus_answers_q.pop_front();
            answers_checked++;
            check_field("access_kind", 16'(want.access_kind), 16'(got.access_kind));
            check_field("bus_address", want.bus_address, got.bus_address);
            check_field("write_byte", 16'(want.write_byte), 16'(got.write_byte));
            check_field("out_af", want.out_af, got.out_af);
            check_field("out_bc", want.out_bc, got.out_bc);
            check_field("out_de", want.out_de, got.out_de);
            check_field("out_hl", want.out_hl, got.out_hl);
            check_field("out_sp", want.out_sp, got.out_sp);
            check_field("out_pc", want.out_pc, got.out_pc);
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    t_in  in_data;
    logic out_valid;
    logic out_ready;
    t_out out_data;
    bit   hold_req;
    int unsigned stall_cycles;
    core_scoreboard sb;

    logic [7:0] known_ops [NUM_OPS] = '{
        OP_NOP, OP_INC_C, OP_LD_C_D8, OP_RRCA, OP_LD_DE, OP_LD_A_DE, OP_JR_NZ,
        OP_LD_HL, OP_LD_SP, OP_LD_HLD_A, OP_LD_A_D8, OP_LD_HL_A, OP_XOR_A,
        OP_PREFIX, OP_CALL, OP_LDH_A8_A, OP_LD_C_A
    };

    cpu_instruction_subset_core_unit u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic t_in mk(logic [1:0] cmd, logic [7:0] d);
        t_in req;
        req.command = cmd;
        req.read_data = d;
        return req;
    endfunction

    function automatic t_in choose_request();
        t_in req;
        int unsigned roll;
        bit writing;
        writing = (sb.phase == PH_WR1) || (sb.phase == PH_WR2);
        roll = $urandom_range(0, 99);
        req.command = CMD_READ;
        req.read_data = 8'($urandom_range(0, 255));
        if (roll < 5) begin
            req.command = CMD_START;
        end else if (roll < 8) begin
            req.command = CMD_NONE;
        end else if (roll < 13) begin
            req.command = writing ? CMD_READ : CMD_ACK;
        end else if (writing) begin
            req.command = CMD_ACK;
        end else if (sb.phase == PH_FETCH) begin
            req.read_data = known_ops[5'($urandom_range(0, NUM_OPS - 1))];
        end else if (sb.phase == PH_CB) begin
            req.read_data = $urandom_range(0, 1) ? CB_SLA_B : CB_BIT7_H;
        end
        return req;
    endfunction

    task automatic offer(input bit random_item, input t_in fixed);
        @(negedge clk);
        in_valid = 1'b1;
        in_data = random_item ? choose_request() : fixed;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic idle(input int unsigned cycles);
        @(negedge clk);
        in_valid = 1'b0;
        repeat (cycles - 1) @(negedge clk);
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.bus_answers_q.size() != 0) @(negedge clk);
    endtask

    initial begin
        int unsigned mode;
        int unsigned seg;
        bit hold_done;
        out_ready = 1'b0;
        hold_done = 1'b0;
        wait (rst_n);
        forever begin
            mode = $urandom_range(0, 2);
            seg = $urandom_range(16, 96);
            repeat (seg) begin
                @(negedge clk);
                if (hold_req && !hold_done) begin
                    out_ready = 1'b0;
                    repeat (LONG_HOLD) @(negedge clk);
                    hold_done = 1'b1;
                end
                case (mode)
                    0: out_ready = 1'b1;
                    1: out_ready = 1'($urandom_range(0, 1));
                    default: out_ready = ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && out_ready) sb.check_answer(out_data);
            if (in_valid && in_ready) sb.note_request(in_data);
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        t_in opening_q[$];
        int unsigned burst_left;
        bit via_prefix;
        sb = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        hold_req = 1'b0;
        burst_left = 0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        opening_q.push_back(mk(CMD_START, 8'h00));
        opening_q.push_back(mk(CMD_READ, OP_LD_A_D8));
        opening_q.push_back(mk(CMD_READ, 8'h81));
        opening_q.push_back(mk(CMD_READ, OP_RRCA));
        opening_q.push_back(mk(CMD_READ, OP_INC_C));
        opening_q.push_back(mk(CMD_READ, OP_LD_HL));
        opening_q.push_back(mk(CMD_READ, 8'h00));
        opening_q.push_back(mk(CMD_READ, 8'h80));
        opening_q.push_back(mk(CMD_READ, OP_PREFIX));
        opening_q.push_back(mk(CMD_READ, CB_BIT7_H));
        opening_q.push_back(mk(CMD_READ, OP_JR_NZ));
        opening_q.push_back(mk(CMD_READ, 8'hFC));
        opening_q.push_back(mk(CMD_READ, OP_CALL));
        opening_q.push_back(mk(CMD_READ, 8'h80));
        opening_q.push_back(mk(CMD_READ, 8'hFF));
        opening_q.push_back(mk(CMD_READ, 8'h55));
        opening_q.push_back(mk(CMD_ACK, 8'h00));
        opening_q.push_back(mk(CMD_ACK, 8'h00));
        opening_q.push_back(mk(CMD_READ, OP_LD_HLD_A));
        opening_q.push_back(mk(CMD_NONE, 8'hFF));
        opening_q.push_back(mk(CMD_START, 8'h00));
        opening_q.push_back(mk(CMD_READ, OP_PREFIX));
        opening_q.push_back(mk(CMD_READ, CB_SLA_B));
        opening_q.push_back(mk(CMD_READ, OP_XOR_A));
        opening_q.push_back(mk(CMD_READ, OP_LD_C_A));
        opening_q.push_back(mk(CMD_ACK, 8'h00));
        opening_q.push_back(mk(CMD_READ, OP_LDH_A8_A));
        opening_q.push_back(mk(CMD_READ, 8'h7F));
        opening_q.push_back(mk(CMD_ACK, 8'h00));
        opening_q.push_back(mk(CMD_READ, OP_LD_A_DE));
        opening_q.push_back(mk(CMD_ACK, 8'h00));
        opening_q.push_back(mk(CMD_READ, 8'h00));
        foreach (opening_q[i]) offer(1'b0, opening_q[i]);

        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            if (burst_left == 0) begin
                if ($urandom_range(0, 3) != 0) idle($urandom_range(1, 8));
                burst_left = $urandom_range(1, 30);
            end
            burst_left--;
            if (n == 250) hold_req = 1'b1;
            if (n == 550) drain();
            offer(1'b1, '0);
        end
        drain();

        via_prefix = 1'($urandom_range(0, 1));
        offer(1'b0, mk(CMD_START, 8'h00));
        if (via_prefix) begin
            offer(1'b0, mk(CMD_READ, OP_PREFIX));
            offer(1'b0, mk(CMD_READ, OP_LD_HL_A));
        end else begin
            offer(1'b0, mk(CMD_READ, 8'hFF));
        end
        offer(1'b0, mk(CMD_START, 8'h00));
        offer(1'b0, mk(CMD_READ, OP_NOP));
        offer(1'b0, mk(CMD_ACK, 8'h00));
        offer(1'b0, mk(CMD_NONE, 8'h00));
        drain();
        repeat (8) @(posedge clk);

        $display("Checked %0d answers to %0d requests: %0d opcodes decoded, %0d writes.",
                 sb.answers_checked, sb.requests_seen, sb.decodes, sb.writes);
        $display("Run included a long receiver hold-off, a full drain and a final fault%s.",
                 via_prefix ? " on a prefixed opcode" : "");
        if (sb.mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
